// File: rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// request codes, status codes and search field codes of the sorted cursor list
// ----------------------------------------------------------------------------
package scl_pkg;

	localparam logic [3:0] REQ_ADD    = 4'd0;
	localparam logic [3:0] REQ_REMOVE = 4'd1;
	localparam logic [3:0] REQ_SEEK   = 4'd2;
	localparam logic [3:0] REQ_NEXT   = 4'd3;
	localparam logic [3:0] REQ_PREV   = 4'd4;
	localparam logic [3:0] REQ_READ   = 4'd5;
	localparam logic [3:0] REQ_SETTAG = 4'd6;
	localparam logic [3:0] REQ_SETID  = 4'd7;
	localparam logic [3:0] REQ_SETTYP = 4'd8;
	localparam logic [3:0] REQ_SETKEY = 4'd9;
	localparam logic [3:0] REQ_SEARCH = 4'd10;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_REF  = 2'd1;
	localparam logic [1:0] ST_EXH  = 2'd2;
	localparam logic [1:0] ST_END  = 2'd3;

	localparam logic [1:0] FLD_TAG  = 2'd0;
	localparam logic [1:0] FLD_ID   = 2'd1;
	localparam logic [1:0] FLD_TYPE = 2'd2;
	localparam logic [1:0] FLD_KEY  = 2'd3;

endpackage

// File: rtl/scl_mem.sv
// ----------------------------------------------------------------------------
// scl_mem
// entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module scl_mem #(
	parameter int W = 72,
	parameter int D = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/sorted_cursor_list.sv
// ----------------------------------------------------------------------------
// sorted_cursor_list
// bounded table kept in descending key order with a cursor on one entry
// ----------------------------------------------------------------------------
// add, remove and set key walk or shift entries one word at a time through the
// single memory read port; search visits one entry per step, bounded by the
// step count (the entry count for zero steps); a new request is taken only
// when idle and the previous result has been taken
// reset clears the count and the cursor; entry memory is undefined until written
// ----------------------------------------------------------------------------
module sorted_cursor_list #(
	parameter int CAPACITY  = 64,
	parameter int KEY_BITS  = 16,
	parameter int ID_BITS   = 16,
	parameter int TYPE_BITS = 8,
	parameter int TAG_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type[3:0] resource_tag[35:4] entry_id[51:36] entry_type[59:52]
	// key_value[75:60] seek_index[81:76] search_field[83:82] step_count[91:84]
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0] out_tag[33:2] out_id[49:34] out_type[57:50] out_key[73:58]
	// count_now[80:74] cursor_valid[81] cursor_pos[87:82]
	output logic [87:0]  m_tdata
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = TAG_BITS + ID_BITS + TYPE_BITS + KEY_BITS;
	localparam int KL = 0;
	localparam int TYL = KEY_BITS;
	localparam int IL = KEY_BITS + TYPE_BITS;
	localparam int TL = KEY_BITS + TYPE_BITS + ID_BITS;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_FINDR = 4'd2,
		S_FINDC = 4'd3, S_SHUPR = 4'd4, S_SHUPW = 4'd5, S_PUT = 4'd6,
		S_SHDNR = 4'd7, S_SHDNW = 4'd8, S_SRCHR = 4'd9, S_SRCHC = 4'd10,
		S_OUTR = 4'd11, S_OUTW = 4'd12, S_HOLD = 4'd13, S_KEYR = 4'd14,
		S_KEYW = 4'd15;

	logic [3:0]          state_q;
	logic [3:0]          req_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [ID_BITS-1:0]  id_q;
	logic [TYPE_BITS-1:0] typ_q;
	logic [KEY_BITS-1:0] key_q;
	logic [5:0]          seek_q;
	logic [1:0]          fld_q;
	logic signed [7:0]   steps_q;
	logic [CW-1:0]       total_q;
	logic [AW-1:0]       cur_q;
	logic                cset_q;
	logic [CW-1:0]       p_q;     // walk / insert position
	logic [CW-1:0]       j_q;     // shift pointer
	logic [CW-1:0]       left_q;  // search steps left
	logic                bwd_q;
	logic                rekey_q; // set key: insert after delete
	logic [1:0]          st_q;
	logic [EW-1:0]       ent_q;   // entry being inserted
	logic                mvalid_q;
	logic [87:0]         mdata_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	scl_mem #(.W(EW), .D(CAPACITY), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic match;
	always_comb begin
		case (fld_q)
			scl_pkg::FLD_TAG:  match = rdata[TL +: TAG_BITS] == tag_q;
			scl_pkg::FLD_ID:   match = rdata[IL +: ID_BITS] == id_q;
			scl_pkg::FLD_TYPE: match = rdata[TYL +: TYPE_BITS] == typ_q;
			default:           match = rdata[KL +: KEY_BITS] == key_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = j_q[AW-1:0];
		wdata = rdata;
		raddr = cur_q;
		case (state_q)
			S_FINDR: raddr = p_q[AW-1:0];
			S_SHUPR: raddr = AW'(j_q - CW'(1));
			S_SHUPW: we = 1'b1;
			S_PUT: begin
				we = 1'b1; waddr = p_q[AW-1:0]; wdata = ent_q;
			end
			S_SHDNR: raddr = AW'(j_q + CW'(1));
			S_SHDNW: we = 1'b1;
			S_SRCHR: raddr = cur_q;
			S_KEYW: begin
				we = 1'b1; waddr = cur_q;
				case (req_q)
					scl_pkg::REQ_SETTAG: wdata[TL +: TAG_BITS] = tag_q;
					scl_pkg::REQ_SETID:  wdata[IL +: ID_BITS] = id_q;
					default:             wdata[TYL +: TYPE_BITS] = typ_q;
				endcase
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE) && !mvalid_q;
	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			cur_q <= '0;
			cset_q <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			if (mvalid_q && m_tready) mvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						req_q <= s_tdata[3:0];
						tag_q <= TAG_BITS'(s_tdata[35:4]);
						id_q <= ID_BITS'(s_tdata[51:36]);
						typ_q <= TYPE_BITS'(s_tdata[59:52]);
						key_q <= KEY_BITS'(s_tdata[75:60]);
						seek_q <= s_tdata[81:76];
						fld_q <= s_tdata[83:82];
						steps_q <= s_tdata[91:84];
						rekey_q <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					st_q <= scl_pkg::ST_REF;
					state_q <= S_OUTR;
					case (req_q)
						scl_pkg::REQ_ADD:
							if (total_q < CW'(CAPACITY)) begin
								ent_q <= {tag_q, id_q, typ_q, key_q};
								p_q <= '0;
								state_q <= S_FINDR;
							end
						scl_pkg::REQ_REMOVE, scl_pkg::REQ_SETKEY:
							if (cset_q) begin
								j_q <= CW'(cur_q);
								state_q <= S_SRCHR; // read the entry first
							end
						scl_pkg::REQ_SEEK:
							if (CW'(seek_q) < total_q && 32'(seek_q) < CAPACITY) begin
								cur_q <= AW'(seek_q);
								cset_q <= 1'b1;
								st_q <= scl_pkg::ST_OK;
							end
						scl_pkg::REQ_NEXT:
							if (!cset_q) st_q <= scl_pkg::ST_EXH;
							else if (CW'(cur_q) + CW'(1) < total_q) begin
								cur_q <= cur_q + AW'(1);
								st_q <= scl_pkg::ST_OK;
							end
						scl_pkg::REQ_PREV:
							if (!cset_q) st_q <= scl_pkg::ST_EXH;
							else if (cur_q != '0) begin
								cur_q <= cur_q - AW'(1);
								st_q <= scl_pkg::ST_OK;
							end
						scl_pkg::REQ_READ:
							if (cset_q) st_q <= scl_pkg::ST_OK;
						scl_pkg::REQ_SETTAG, scl_pkg::REQ_SETID, scl_pkg::REQ_SETTYP:
							if (cset_q) begin
								st_q <= scl_pkg::ST_OK;
								state_q <= S_KEYR;
							end
						scl_pkg::REQ_SEARCH:
							if (total_q != '0) begin
								bwd_q <= steps_q[7];
								if (!cset_q) begin
									cur_q <= steps_q[7] ? AW'(total_q - CW'(1)) : '0;
									cset_q <= 1'b1;
								end
								left_q <= (steps_q == 8'sd0) ? total_q :
									steps_q[7] ? CW'(-steps_q) : CW'(steps_q);
								state_q <= S_SRCHR;
							end
						default: ;
					endcase
				end
				S_KEYR: state_q <= S_KEYW;
				S_KEYW: state_q <= S_OUTR;
				S_FINDR: state_q <= S_FINDC;
				S_FINDC: begin
					if (p_q < total_q && rdata[KL +: KEY_BITS] > ent_q[KL +: KEY_BITS]) begin
						p_q <= p_q + CW'(1);
						state_q <= S_FINDR;
					end else begin
						j_q <= total_q;
						state_q <= (total_q == p_q) ? S_PUT : S_SHUPR;
					end
				end
				S_SHUPR: state_q <= S_SHUPW;
				S_SHUPW: begin
					j_q <= j_q - CW'(1);
					state_q <= (j_q - CW'(1) == p_q) ? S_PUT : S_SHUPR;
				end
				S_PUT: begin
					total_q <= total_q + CW'(1);
					if (cset_q && CW'(cur_q) >= p_q) cur_q <= cur_q + AW'(1);
					st_q <= scl_pkg::ST_OK;
					state_q <= S_OUTR;
				end
				S_SRCHR: state_q <= S_SRCHC;
				S_SRCHC: begin
					if (req_q != scl_pkg::REQ_SEARCH) begin
						// remove / set key: capture entry, close the gap
						ent_q <= {rdata[EW-1:KEY_BITS], key_q};
						rekey_q <= (req_q == scl_pkg::REQ_SETKEY);
						cset_q <= 1'b0;
						state_q <= (j_q + CW'(1) < total_q) ? S_SHDNR : S_HOLD;
					end else if (match) begin
						st_q <= scl_pkg::ST_OK; state_q <= S_OUTR;
					end else if (bwd_q ? (cur_q == '0) : (CW'(cur_q) + CW'(1) >= total_q)) begin
						st_q <= scl_pkg::ST_END; state_q <= S_OUTR;
					end else begin
						cur_q <= bwd_q ? cur_q - AW'(1) : cur_q + AW'(1);
						left_q <= left_q - CW'(1);
						if (left_q == CW'(1)) begin
							st_q <= scl_pkg::ST_EXH; state_q <= S_OUTR;
						end else state_q <= S_SRCHR;
					end
				end
				S_SHDNR: state_q <= S_SHDNW;
				S_SHDNW: begin
					j_q <= j_q + CW'(1);
					state_q <= (j_q + CW'(2) < total_q) ? S_SHDNR : S_HOLD;
				end
				S_HOLD: begin
					total_q <= total_q - CW'(1);
					cur_q <= '0;
					st_q <= scl_pkg::ST_OK;
					if (rekey_q) begin
						p_q <= '0;
						state_q <= S_FINDR;
					end else state_q <= S_OUTR;
				end
				S_OUTR: state_q <= S_OUTW;
				S_OUTW: begin
					mvalid_q <= 1'b1;
					if (cset_q && CW'(cur_q) < total_q) begin
						mdata_q <= {6'(cur_q), 1'b1, 7'(total_q),
							16'(rdata[KL +: KEY_BITS]), 8'(rdata[TYL +: TYPE_BITS]),
							16'(rdata[IL +: ID_BITS]), 32'(rdata[TL +: TAG_BITS]), st_q};
					end else begin
						mdata_q <= {6'd0, 1'b0, 7'(total_q), 72'd0, st_q};
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
